// ===== design/assert_macros.svh =====
// assertion macros used by the top level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== design/mctt_pkg.sv =====
// types and constants of the midi clock tap tempo block
package mctt_pkg;

	localparam int DIV_W   = 32;
	localparam int TEMPO_W = 10;
	localparam int PPQ_W   = 7;
	localparam int TMO_W   = 16;
	localparam int PROD_W  = TEMPO_W + PPQ_W;
	localparam int IVL_W   = 26;
	localparam int REQ_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [DIV_W-1:0] US_PER_MINUTE = 32'd60000000;
	localparam logic [DIV_W-1:0] MS_PER_MINUTE = 32'd60000;

	localparam logic [7:0] BYTE_CLOCK    = 8'hF8;
	localparam logic [7:0] BYTE_START    = 8'hFA;
	localparam logic [7:0] BYTE_CONTINUE = 8'hFB;
	localparam logic [7:0] BYTE_STOP     = 8'hFC;

	localparam logic [REQ_W-1:0] REQ_POLL     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_TAP      = 3'd1;
	localparam logic [REQ_W-1:0] REQ_START    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_STOP     = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CONTINUE = 3'd4;
	localparam logic [REQ_W-1:0] REQ_SET_TEMPO  = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SET_ENABLE = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMPO   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMPO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIMEOUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PPQ         = 2'd3;

	localparam logic [TEMPO_W-1:0] RST_MIN_TEMPO = 10'd30;
	localparam logic [TEMPO_W-1:0] RST_MAX_TEMPO = 10'd300;
	localparam logic [TMO_W-1:0]   RST_TIMEOUT   = 16'd2000;
	localparam logic [PPQ_W-1:0]   RST_PPQ       = 7'd24;
	localparam logic [TEMPO_W-1:0] RST_TEMPO     = 10'd120;
	// 60000000 / (120 * 24)
	localparam logic [IVL_W-1:0]   RST_INTERVAL  = 26'd20833;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== design/mctt_ifs.sv =====
// request and response channel interfaces
interface mctt_req_if import mctt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REQ_W-1:0]     req_type;
	logic [31:0]          time_us;
	logic [31:0]          time_ms;
	logic [15:0]          tempo_request;
	logic                 enable_request;

	modport source (output valid, req_type, time_us, time_ms, tempo_request, enable_request,
		input ready);
	modport sink (input valid, req_type, time_us, time_ms, tempo_request, enable_request,
		output ready);
endinterface

interface mctt_rsp_if import mctt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               msg_valid;
	logic [7:0]         msg_byte;
	logic [TEMPO_W-1:0] tempo_now;
	logic               is_running;
	logic               is_enabled;

	modport source (output valid, msg_valid, msg_byte, tempo_now, is_running, is_enabled,
		input ready);
	modport sink (input valid, msg_valid, msg_byte, tempo_now, is_running, is_enabled,
		output ready);
endinterface

// ===== design/mctt_div.sv =====
// shared restoring divider, one quotient bit per cycle
module mctt_div import mctt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output div_stat_t        stat,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dsr_q;

	logic [DIV_W:0]   rem_sh;
	logic [DIV_W:0]   diff;

	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign diff   = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end else if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ===== design/midi_clock_tap_tempo.sv =====
// midi clock generator with tap tempo, top level
//
//  channel | dir | handshake          | carries
//  --------+-----+--------------------+-----------------------------------------------
//  req     | in  | valid / ready      | req_type, time_us, time_ms, tempo_request, ...
//  rsp     | out | valid / ready      | msg_valid, msg_byte, tempo_now, flags
//  cfg     | in  | cfg_we, no wait    | cfg_idx, cfg_data
//
// one transaction at a time: start, stop, continue, enable and unused codes go straight
// to the final step, poll through two poll steps, set tempo a multiply then one divide,
// a tap up to three divides; all divides run on the one shared divider
// reset is asynchronous, active low, and leaves tempo 120 with its interval, flags cleared
// the result sits in an output register; a stalled rsp holds the block in its last step
// and req stays low until the sequencer is back in idle
`include "assert_macros.svh"

module midi_clock_tap_tempo import mctt_pkg::*; #(
	parameter int TAP_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mctt_req_if.sink              req,
	mctt_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// tap counter holds 0..TAP_DEPTH, history index 0..TAP_DEPTH-1
	localparam int TC_W  = $clog2(TAP_DEPTH + 1);
	localparam int IDX_W = $clog2(TAP_DEPTH);

	// sequencer codes
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_POLL1 = 4'd1;
	localparam logic [3:0] S_POLL2 = 4'd2;
	localparam logic [3:0] S_TAP1  = 4'd3;
	localparam logic [3:0] S_TAP2  = 4'd4;
	localparam logic [3:0] S_DIVM  = 4'd5;
	localparam logic [3:0] S_DIVB  = 4'd6;
	localparam logic [3:0] S_MUL   = 4'd7;
	localparam logic [3:0] S_INT   = 4'd8;
	localparam logic [3:0] S_DIVI  = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	logic [3:0]         state_q;

	// configuration
	logic [TEMPO_W-1:0] min_tempo_q;
	logic [TEMPO_W-1:0] max_tempo_q;
	logic [TMO_W-1:0]   timeout_q;
	logic [PPQ_W-1:0]   ppq_q;

	// architectural state
	logic [TEMPO_W-1:0] tempo_q;
	logic [IVL_W-1:0]   interval_q;
	logic [31:0]        last_pulse_q;
	logic [TC_W-1:0]    tap_count_q;
	logic [31:0]        last_tap_q;
	logic               enabled_q;
	logic               running_q;
	logic [31:0]        hist_q [TAP_DEPTH];

	// latched transaction and working registers
	logic [31:0]        t_us_q;
	logic [31:0]        t_ms_q;
	logic               msg_valid_q;
	logic [7:0]         msg_byte_q;
	logic               hit_q;
	logic [31:0]        sum_q;
	logic [PROD_W-1:0]  prod_q;

	// response register
	logic               rsp_valid_q;
	logic               rsp_msg_valid_q;
	logic [7:0]         rsp_byte_q;
	logic [TEMPO_W-1:0] rsp_tempo_q;
	logic               rsp_run_q;
	logic               rsp_en_q;

	// divider hookup
	logic               div_go;
	logic [DIV_W-1:0]   div_a;
	logic [DIV_W-1:0]   div_b;
	div_stat_t          div_st;
	logic [DIV_W-1:0]   div_q;

	logic               accept;
	logic               out_free;
	logic [15:0]        treq_lo;
	logic [15:0]        treq_cl;
	logic               tap_restart;
	logic [TC_W-1:0]    cnt_eff;
	logic               tap_full;
	logic               bpm_ok;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !rsp_valid_q || rsp.ready;

	// set tempo: raise to min first, then lower to max
	assign treq_lo = (req.tempo_request < 16'(min_tempo_q)) ? 16'(min_tempo_q)
		: req.tempo_request;
	assign treq_cl = (treq_lo > 16'(max_tempo_q)) ? 16'(max_tempo_q) : treq_lo;

	// tap history restarts after a long gap (wrapping difference)
	assign tap_restart = (tap_count_q != '0) && ((t_ms_q - last_tap_q) > 32'(timeout_q));
	assign cnt_eff     = tap_restart ? '0 : tap_count_q;
	assign tap_full    = (cnt_eff >= TC_W'(TAP_DEPTH));

	// tapped bpm must fit the configured window
	assign bpm_ok = (div_q <= 32'(max_tempo_q)) && (div_q >= 32'(min_tempo_q));

	// divider operand selection per sequencer step
	always_comb begin
		div_go = 1'b0;
		div_a  = US_PER_MINUTE;
		div_b  = 32'(prod_q);
		unique case (state_q)
			S_TAP2: begin
				// sum of tap gaps telescopes to newest minus oldest
				div_go = (tap_count_q >= TC_W'(2));
				div_a  = t_ms_q - hist_q[0];
				div_b  = 32'(tap_count_q - 1'b1);
			end
			S_DIVM: begin
				div_go = div_st.done && (div_q != '0);
				div_a  = MS_PER_MINUTE;
				div_b  = div_q;
			end
			S_INT: begin
				div_go = (prod_q != '0);
			end
			default: begin
				div_go = 1'b0;
			end
		endcase
	end

	mctt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_a),
		.divisor  (div_b),
		.stat     (div_st),
		.quotient (div_q)
	);

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			min_tempo_q  <= RST_MIN_TEMPO;
			max_tempo_q  <= RST_MAX_TEMPO;
			timeout_q    <= RST_TIMEOUT;
			ppq_q        <= RST_PPQ;
			tempo_q      <= RST_TEMPO;
			interval_q   <= RST_INTERVAL;
			last_pulse_q <= '0;
			tap_count_q  <= '0;
			last_tap_q   <= '0;
			enabled_q    <= 1'b0;
			running_q    <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_MIN_TEMPO:   min_tempo_q <= cfg_data[TEMPO_W-1:0];
					CFG_MAX_TEMPO:   max_tempo_q <= cfg_data[TEMPO_W-1:0];
					CFG_TAP_TIMEOUT: timeout_q   <= cfg_data[TMO_W-1:0];
					CFG_PPQ:         ppq_q       <= cfg_data[PPQ_W-1:0];
				endcase
			end

			if (rsp.ready)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FIN;
						unique case (req.req_type)
							REQ_POLL: state_q <= S_POLL1;
							REQ_TAP:  state_q <= S_TAP1;
							REQ_START, REQ_CONTINUE: begin
								if (enabled_q) begin
									running_q    <= 1'b1;
									last_pulse_q <= req.time_us;
								end
							end
							REQ_STOP: running_q <= 1'b0;
							REQ_SET_TEMPO: begin
								tempo_q <= treq_cl[TEMPO_W-1:0];
								state_q <= S_MUL;
							end
							REQ_SET_ENABLE: begin
								enabled_q <= req.enable_request;
								if (!req.enable_request)
									running_q <= 1'b0;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_POLL1: state_q <= S_POLL2;
				S_POLL2: begin
					if (hit_q) begin
						// resync when still more than two intervals behind
						if ((t_us_q - sum_q) > 32'({interval_q, 1'b0}))
							last_pulse_q <= t_us_q;
						else
							last_pulse_q <= sum_q;
					end
					state_q <= S_FIN;
				end
				S_TAP1: begin
					tap_count_q <= tap_full ? cnt_eff : cnt_eff + 1'b1;
					last_tap_q  <= t_ms_q;
					state_q     <= S_TAP2;
				end
				S_TAP2: state_q <= div_go ? S_DIVM : S_FIN;
				S_DIVM: begin
					if (div_st.done)
						state_q <= div_go ? S_DIVB : S_FIN;
				end
				S_DIVB: begin
					if (div_st.done) begin
						if (bpm_ok) begin
							tempo_q <= div_q[TEMPO_W-1:0];
							state_q <= S_MUL;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_MUL: state_q <= S_INT;
				S_INT: state_q <= div_go ? S_DIVI : S_FIN;
				S_DIVI: begin
					if (div_st.done) begin
						interval_q <= div_q[IVL_W-1:0];
						state_q    <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					t_us_q      <= req.time_us;
					t_ms_q      <= req.time_ms;
					msg_valid_q <= 1'b0;
					msg_byte_q  <= '0;
					unique case (req.req_type)
						REQ_START, REQ_CONTINUE: begin
							if (enabled_q) begin
								msg_valid_q <= 1'b1;
								msg_byte_q  <= (req.req_type == REQ_START) ? BYTE_START
									: BYTE_CONTINUE;
							end
						end
						REQ_STOP: begin
							msg_valid_q <= 1'b1;
							msg_byte_q  <= BYTE_STOP;
						end
						REQ_SET_ENABLE: begin
							if (!req.enable_request && running_q) begin
								msg_valid_q <= 1'b1;
								msg_byte_q  <= BYTE_STOP;
							end
						end
						default: msg_valid_q <= 1'b0;
					endcase
				end
			end
			S_POLL1: begin
				hit_q <= enabled_q && running_q
					&& ((t_us_q - last_pulse_q) >= 32'(interval_q));
				sum_q <= last_pulse_q + 32'(interval_q);
			end
			S_POLL2: begin
				if (hit_q) begin
					msg_valid_q <= 1'b1;
					msg_byte_q  <= BYTE_CLOCK;
				end
			end
			S_TAP1: begin
				if (!tap_full) begin
					hist_q[cnt_eff[IDX_W-1:0]] <= t_ms_q;
				end else begin
					// drop the oldest tap
					for (int i = 0; i < TAP_DEPTH - 1; i++)
						hist_q[i] <= hist_q[i + 1];
					hist_q[TAP_DEPTH-1] <= t_ms_q;
				end
			end
			S_MUL: prod_q <= tempo_q * ppq_q;
			S_FIN: begin
				if (out_free) begin
					rsp_msg_valid_q <= msg_valid_q;
					rsp_byte_q      <= msg_byte_q;
					rsp_tempo_q     <= tempo_q;
					rsp_run_q       <= running_q;
					rsp_en_q        <= enabled_q;
				end
			end
			default: begin
				hit_q <= hit_q;
			end
		endcase
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.msg_valid  = rsp_msg_valid_q;
	assign rsp.msg_byte   = rsp_byte_q;
	assign rsp.tempo_now  = rsp_tempo_q;
	assign rsp.is_running = rsp_run_q;
	assign rsp.is_enabled = rsp_en_q;

	// an accepted transaction always moves the sequencer out of idle
	`ASSERT_HOLDS(a_accept_leaves_idle, clk, arst_n, accept |=> (state_q != S_IDLE))
	// a result only appears from the final step
	`ASSERT_HOLDS(a_rsp_from_fin, clk, arst_n, $rose(rsp_valid_q) |-> $past(state_q == S_FIN))
	// the clock never runs while disabled
	`ASSERT_NEVER(a_run_needs_enable, clk, arst_n, rsp.valid && rsp.is_running && !rsp.is_enabled)
	// the shared divider is never restarted mid division
	`ASSERT_NEVER(a_div_no_overlap, clk, arst_n, div_go && div_st.busy)

endmodule

// ===== bench/mctt_clock_checker.sv =====
// checker that predicts and compares the replies of the midi clock tap tempo block
`timescale 1ns / 100ps

module mctt_clock_checker import mctt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mctt_req_if                   req,
	mctt_rsp_if                   rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    replies_owed,
	output int                    clock_bytes
);

	localparam int TAP_SLOTS = 4;

	typedef struct packed {
		logic               msg_valid;
		logic [7:0]         msg_byte;
		logic [TEMPO_W-1:0] tempo_now;
		logic               is_running;
		logic               is_enabled;
	} clock_reply_t;

	// register copies
	logic [TEMPO_W-1:0] floor_bpm;
	logic [TEMPO_W-1:0] ceil_bpm;
	logic [TMO_W-1:0]   tap_window;
	logic [PPQ_W-1:0]   ppq;

	// predicted block state
	logic [TEMPO_W-1:0] bpm;
	logic [31:0]        tick_us;
	logic [31:0]        prev_tick;
	logic [31:0]        tap_ms [TAP_SLOTS];
	int unsigned        taps_held;
	logic [31:0]        prev_tap;
	logic               enabled;
	logic               running;

	clock_reply_t owed_replies [$];
	clock_reply_t seen;
	clock_reply_t want;

	function automatic void refresh_interval();
		logic [31:0] prod;
		prod = 32'(bpm) * 32'(ppq);
		if (prod != 0)
			tick_us = US_PER_MINUTE / prod;
	endfunction

	function automatic void register_tap(input logic [31:0] now);
		logic [31:0] since;
		logic [31:0] gap_sum;
		logic [31:0] mean;
		logic [31:0] tap_bpm;
		since = now - prev_tap;
		if (taps_held > 0 && since > 32'(tap_window))
			taps_held = 0;
		if (taps_held < TAP_SLOTS) begin
			tap_ms[taps_held] = now;
			taps_held++;
		end else begin
			for (int i = 0; i < TAP_SLOTS - 1; i++)
				tap_ms[i] = tap_ms[i + 1];
			tap_ms[TAP_SLOTS - 1] = now;
		end
		prev_tap = now;
		if (taps_held >= 2) begin
			gap_sum = '0;
			for (int i = 0; i < taps_held - 1; i++)
				gap_sum += tap_ms[i + 1] - tap_ms[i];
			mean = gap_sum / (taps_held - 1);
			if (mean != 0) begin
				tap_bpm = MS_PER_MINUTE / mean;
				if (tap_bpm >= 32'(floor_bpm) && tap_bpm <= 32'(ceil_bpm)) begin
					bpm = tap_bpm[TEMPO_W-1:0];
					refresh_interval();
				end
			end
		end
	endfunction

	function automatic clock_reply_t next_clock_reply(input logic [REQ_W-1:0] kind,
		input logic [31:0] at_us, input logic [31:0] at_ms, input logic [15:0] bpm_ask,
		input logic en_ask);
		clock_reply_t r;
		logic [31:0]  lag;
		logic [15:0]  clamped;
		r = '0;
		case (kind)
		REQ_POLL: begin
			lag = at_us - prev_tick;
			if (enabled && running && lag >= tick_us) begin
				r.msg_valid = 1'b1;
				r.msg_byte  = BYTE_CLOCK;
				prev_tick   = prev_tick + tick_us;
				lag         = at_us - prev_tick;
				// fell behind by more than two pulses: snap to now
				if (lag > {tick_us[30:0], 1'b0})
					prev_tick = at_us;
			end
		end
		REQ_TAP: register_tap(at_ms);
		REQ_START, REQ_CONTINUE: begin
			if (enabled) begin
				running     = 1'b1;
				prev_tick   = at_us;
				r.msg_valid = 1'b1;
				r.msg_byte  = (kind == REQ_START) ? BYTE_START : BYTE_CONTINUE;
			end
		end
		REQ_STOP: begin
			running     = 1'b0;
			r.msg_valid = 1'b1;
			r.msg_byte  = BYTE_STOP;
		end
		REQ_SET_TEMPO: begin
			clamped = bpm_ask;
			if (clamped < 16'(floor_bpm))
				clamped = 16'(floor_bpm);
			if (clamped > 16'(ceil_bpm))
				clamped = 16'(ceil_bpm);
			bpm = clamped[TEMPO_W-1:0];
			refresh_interval();
		end
		REQ_SET_ENABLE: begin
			enabled = en_ask;
			if (!en_ask && running) begin
				running     = 1'b0;
				r.msg_valid = 1'b1;
				r.msg_byte  = BYTE_STOP;
			end
		end
		default: ;
		endcase
		r.tempo_now  = bpm;
		r.is_running = running;
		r.is_enabled = enabled;
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] expected,
		input logic [31:0] actual);
		if (expected !== actual) begin
			mismatches++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, expected, actual);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_bpm  = RST_MIN_TEMPO;
			ceil_bpm   = RST_MAX_TEMPO;
			tap_window = RST_TIMEOUT;
			ppq        = RST_PPQ;
			bpm        = RST_TEMPO;
			tick_us    = 32'(RST_INTERVAL);
			prev_tick  = '0;
			taps_held  = 0;
			prev_tap   = '0;
			enabled    = 1'b0;
			running    = 1'b0;
			owed_replies.delete();
			replies_owed = 0;
			mismatches   = 0;
			clock_bytes  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
				CFG_MIN_TEMPO:   floor_bpm  = cfg_data[TEMPO_W-1:0];
				CFG_MAX_TEMPO:   ceil_bpm   = cfg_data[TEMPO_W-1:0];
				CFG_TAP_TIMEOUT: tap_window = cfg_data[TMO_W-1:0];
				CFG_PPQ:         ppq        = cfg_data[PPQ_W-1:0];
				default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				seen = {rsp.msg_valid, rsp.msg_byte, rsp.tempo_now, rsp.is_running,
					rsp.is_enabled};
				if (owed_replies.size() == 0) begin
					mismatches++;
					$display("%0t: reply expected none, got valid %0b byte 0x%0h tempo %0d",
						$time, seen.msg_valid, seen.msg_byte, seen.tempo_now);
				end else begin
					want = owed_replies.pop_front();
					check_field("msg_valid", want.msg_valid, seen.msg_valid);
					check_field("msg_byte", want.msg_byte, seen.msg_byte);
					check_field("tempo_now", want.tempo_now, seen.tempo_now);
					check_field("is_running", want.is_running, seen.is_running);
					check_field("is_enabled", want.is_enabled, seen.is_enabled);
					if (want.msg_valid && want.msg_byte == BYTE_CLOCK)
						clock_bytes++;
				end
			end
			if (req.valid && req.ready)
				owed_replies.push_back(next_clock_reply(req.req_type, req.time_us,
					req.time_ms, req.tempo_request, req.enable_request));
			replies_owed = owed_replies.size();
		end
	end

endmodule

// ===== bench/tb_midi_clock_tap_tempo.sv =====
// stimulus and verdict for the midi clock tap tempo block
`timescale 1ns / 100ps

module tb_midi_clock_tap_tempo import mctt_pkg::*;;

	// request code the block does not use
	localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	mctt_req_if req_if ();
	mctt_rsp_if rsp_if ();

	int mismatches;
	int replies_owed;
	int clock_bytes;

	// percent of cycles in which each side holds off
	int req_gap_pct;
	int rsp_gap_pct;

	int unsigned events_sent;
	int unsigned settings_used;

	// running time base shared by all events
	logic [31:0] now_us;
	logic [31:0] now_ms;

	// what the stimulus knows of the current settings, to aim timestamps
	int unsigned lo_bpm;
	int unsigned hi_bpm;
	int unsigned window_ms;
	int unsigned ppq_now;
	int unsigned bpm_guess;

	midi_clock_tap_tempo #(.TAP_DEPTH(4)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	mctt_clock_checker reply_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_if),
		.rsp          (rsp_if),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.replies_owed (replies_owed),
		.clock_bytes  (clock_bytes)
	);

	always #6 clk = ~clk;

	// hard stop if the block hangs
	initial begin
		#12_000_000;
		$display("tb: failure");
		$finish;
	end

	// receiver stalls at random, redrawn every cycle
	always @(posedge clk) begin
		rsp_if.ready <= arst_n && (int'($urandom_range(99)) >= rsp_gap_pct);
	end

	// interval the block should be using, as far as the stimulus can tell
	function automatic int unsigned pulse_guess();
		return 60000000 / (bpm_guess * ppq_now);
	endfunction

	function automatic void pass_time(input int unsigned us);
		now_us += us;
		now_ms += us / 1000;
	endfunction

	// one transaction on the request channel, with random hold-off first
	task automatic send_event(input logic [REQ_W-1:0] kind, input logic [31:0] at_us,
		input logic [31:0] at_ms, input logic [15:0] bpm_ask, input logic en_ask);
		while (int'($urandom_range(99)) < req_gap_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid          <= 1'b1;
		req_if.req_type       <= kind;
		req_if.time_us        <= at_us;
		req_if.time_ms        <= at_ms;
		req_if.tempo_request  <= bpm_ask;
		req_if.enable_request <= en_ask;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		events_sent++;
	endtask

	// hold the sender until every owed reply is back
	task automatic drain_replies();
		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (replies_owed != 0);
	endtask

	// writes all four registers on consecutive cycles, block idle
	task automatic load_settings(input int unsigned lo, input int unsigned hi,
		input int unsigned tmo, input int unsigned quarter_ppq);
		logic [CFG_IDX_W-1:0] slot [4];
		int unsigned          word [4];
		slot = '{CFG_MIN_TEMPO, CFG_MAX_TEMPO, CFG_TAP_TIMEOUT, CFG_PPQ};
		word = '{lo, hi, tmo, quarter_ppq};
		for (int i = 0; i < 4; i++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= slot[i];
			cfg_data <= word[i][CFG_DATA_W-1:0];
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		lo_bpm    = lo;
		hi_bpm    = hi;
		window_ms = tmo;
		ppq_now   = quarter_ppq;
		settings_used++;
	endtask

	// mostly well-formed clock sessions and tap bursts, else tempo asks, refused starts or noise
	task automatic random_traffic(input int unsigned budget);
		int unsigned stop_at;
		int unsigned ivl;
		int unsigned tap_bpm;
		int unsigned gap;
		int unsigned hop_ms;
		int unsigned band_lo;
		int unsigned band_hi;
		int unsigned g;
		logic [15:0] ask;
		stop_at = events_sent + budget;
		while (events_sent < stop_at) begin
			// now and then let everything settle mid-stream
			if ($urandom_range(59) == 0)
				drain_replies();
			case ($urandom_range(9))
			0, 1, 2, 3: begin
				// enable, start or continue, a run of polls, then usually stop
				if ($urandom_range(4) != 0)
					send_event(REQ_SET_ENABLE, now_us, now_ms, $urandom_range(65535), 1'b1);
				send_event($urandom_range(1) ? REQ_START : REQ_CONTINUE, now_us, now_ms,
					$urandom_range(65535), $urandom_range(1));
				repeat ($urandom_range(40, 8)) begin
					ivl = pulse_guess();
					case ($urandom_range(15))
					0: pass_time(3 * ivl + $urandom_range(ivl));    // forces a resync
					1: pass_time($urandom_range(ivl / 8));          // too early
					default: pass_time($urandom_range(ivl * 5 / 4, ivl / 2));
					endcase
					send_event(REQ_POLL, now_us, now_ms, $urandom_range(65535),
						$urandom_range(1));
				end
				case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					send_event(REQ_STOP, now_us, now_ms, $urandom_range(65535),
						$urandom_range(1));
				end
				6, 7, 8: begin
					send_event(REQ_SET_ENABLE, now_us, now_ms, $urandom_range(65535), 1'b0);
				end
				default: ;
				endcase
			end
			4, 5: begin
				// tap burst near one tempo, with timeouts, repeats and long gaps mixed in
				band_lo = (lo_bpm < hi_bpm) ? lo_bpm : hi_bpm;
				band_hi = (lo_bpm < hi_bpm) ? hi_bpm : lo_bpm;
				tap_bpm = $urandom_range(band_hi, band_lo);
				gap     = 60000 / tap_bpm;
				repeat ($urandom_range(6, 2)) begin
					case ($urandom_range(11))
					0: hop_ms = window_ms + $urandom_range(3000, 1);
					1: hop_ms = 0;
					2: hop_ms = $urandom_range(window_ms);
					default: hop_ms = gap - gap / 8 + $urandom_range(gap / 4);
					endcase
					now_ms += hop_ms;
					now_us += hop_ms * 1000;
					send_event(REQ_TAP, now_us, now_ms, $urandom_range(65535),
						$urandom_range(1));
				end
				if (lo_bpm <= hi_bpm)
					bpm_guess = tap_bpm;
			end
			6: begin
				// tempo requests inside, outside and at the ends of the range
				case ($urandom_range(3))
				0: ask = $urandom_range(65535);
				1: ask = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				2: ask = $urandom_range(1) ? lo_bpm - 1 : hi_bpm + 1;
				default: ask = $urandom_range(hi_bpm, lo_bpm);
				endcase
				send_event(REQ_SET_TEMPO, now_us, now_ms, ask, $urandom_range(1));
				g = ask;
				if (g < lo_bpm)
					g = lo_bpm;
				if (g > hi_bpm)
					g = hi_bpm;
				bpm_guess = g;
			end
			7: begin
				// start or continue refused while disabled
				send_event(REQ_SET_ENABLE, now_us, now_ms, $urandom_range(65535), 1'b0);
				send_event($urandom_range(1) ? REQ_START : REQ_CONTINUE, now_us, now_ms,
					$urandom_range(65535), $urandom_range(1));
				pass_time(pulse_guess());
				send_event(REQ_POLL, now_us, now_ms, $urandom_range(65535), $urandom_range(1));
			end
			default: begin
				// any code, any field value
				send_event($urandom_range(7), $urandom, $urandom, $urandom_range(65535),
					$urandom_range(1));
			end
			endcase
		end
	endtask

	initial begin
		// every input known from time zero, reset held low at the start and released on a clock edge
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_idx               = CFG_MIN_TEMPO;
		cfg_data              = '0;
		req_if.valid          = 1'b0;
		req_if.req_type       = REQ_POLL;
		req_if.time_us        = '0;
		req_if.time_ms        = '0;
		req_if.tempo_request  = '0;
		req_if.enable_request = 1'b0;
		rsp_if.ready          = 1'b0;
		req_gap_pct           = 24;
		rsp_gap_pct           = 45;
		events_sent           = 0;
		settings_used         = 0;
		now_us                = '0;
		now_ms                = '0;
		lo_bpm                = 30;
		hi_bpm                = 300;
		window_ms             = 2000;
		ppq_now               = 24;
		bpm_guess             = 120;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset settings: 120 bpm at 24 ppq is a 20833 us pulse
		// everything refused or silent while disabled, stop always answers
		send_event(REQ_POLL, 32'd0, 32'd0, 16'd0, 1'b0);
		send_event(REQ_START, 32'd0, 32'd0, 16'd0, 1'b0);
		send_event(REQ_CONTINUE, 32'd0, 32'd0, 16'd0, 1'b0);
		send_event(REQ_STOP, 32'd0, 32'd0, 16'd0, 1'b0);
		send_event(REQ_SET_ENABLE, 32'd0, 32'd0, 16'd0, 1'b1);
		// clamp to min, clamp to max, then back to 120
		send_event(REQ_SET_TEMPO, 32'd0, 32'd0, 16'h0000, 1'b0);
		send_event(REQ_SET_TEMPO, 32'd0, 32'd0, 16'hFFFF, 1'b0);
		send_event(REQ_SET_TEMPO, 32'd0, 32'd0, 16'd120, 1'b0);
		// start just below the wrap of the microsecond counter
		now_us = 32'hFFFF_F000;
		now_ms = 32'hFFFF_FF00;
		send_event(REQ_START, now_us, now_ms, 16'd0, 1'b0);
		// one short of a pulse, exactly a pulse across the wrap, then far behind
		send_event(REQ_POLL, now_us + 32'd20832, now_ms, 16'd0, 1'b0);
		now_us += 32'd20833;
		send_event(REQ_POLL, now_us, now_ms, 16'd0, 1'b0);
		now_us += 32'd20833 * 11;
		send_event(REQ_POLL, now_us, now_ms, 16'd0, 1'b0);
		send_event(REQ_CONTINUE, now_us, now_ms, 16'd0, 1'b0);
		// five taps 400 ms apart across the ms wrap: 150 bpm, the fifth drops the oldest
		repeat (5) begin
			send_event(REQ_TAP, now_us, now_ms, 16'd0, 1'b0);
			now_ms += 32'd400;
		end
		// gap past the timeout restarts history, a repeat tap gives a zero mean
		now_ms += 32'd1601;
		send_event(REQ_TAP, now_us, now_ms, 16'd0, 1'b0);
		send_event(REQ_TAP, now_us, now_ms, 16'd0, 1'b0);
		send_event(REQ_UNUSED, '1, '1, '1, 1'b1);
		// disable while running sends stop, disable again is silent
		send_event(REQ_SET_ENABLE, now_us, now_ms, 16'd0, 1'b0);
		send_event(REQ_SET_ENABLE, now_us, now_ms, 16'd0, 1'b0);
		send_event(REQ_POLL, '1, '1, '1, 1'b1);
		bpm_guess = 150;

		// random phases, each on its own register settings, written while idle
		random_traffic(260);
		drain_replies();
		load_settings(1, 1023, 0, 1);
		random_traffic(260);

		req_gap_pct = 45;
		rsp_gap_pct = 24;
		drain_replies();
		load_settings(1023, 1023, 65535, 96);
		random_traffic(260);
		drain_replies();
		// min above max: clamps land on max, taps never accepted
		load_settings(200, 100, 500, 24);
		random_traffic(260);

		req_gap_pct = 0;
		rsp_gap_pct = 0;
		drain_replies();
		load_settings($urandom_range(200, 20), $urandom_range(600, 250),
			$urandom_range(3000, 300), $urandom_range(96, 1));
		random_traffic(260);
		drain_replies();
		load_settings(30, 300, 2000, 24);
		random_traffic(260);

		// all replies in, then room for a stray one after the longest tap
		drain_replies();
		repeat (120) @(posedge clk);
		$display("run covered %0d events under %0d register settings, %0d clock pulses checked",
			events_sent, settings_used, clock_bytes);
		if (mismatches == 0 && replies_owed == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
